[sv/trial_division_prime_test_assert.svh]
// Assertion macros for the trial division prime test block.
// Included by the top level; depends on nothing else.
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`ifndef SYNTH
`define TDPT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdpt same-cycle check failed");
`define TDPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdpt next-cycle check failed");
`else
`define TDPT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TDPT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/tdpt_pkg.sv]
// Shared constants and controller/datapath interface types for the prime test.
// Depends on nothing.
`default_nettype none
package tdpt_pkg;
   localparam int WIDTH_DEFAULT = 32;
   localparam int FIRST_DIVISOR = 3;
   localparam int DIVISOR_STEP = 2;
   localparam int LOWEST_PRIME = 2;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic next_divisor;
   } tdpt_cmd_type;

   typedef struct packed {
      logic below_two;
      logic equals_two;
      logic is_even;
      logic step_last;
      logic rem_zero;
      logic div_in_range;
   } tdpt_status_type;
endpackage
`default_nettype wire

[sv/tdpt_dp.sv]
// Datapath: holds the number and trial divisor, and runs a restoring divider.
// Depends on tdpt_pkg.
`default_nettype none
module tdpt_dp #(
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic [WIDTH-1:0]         number,
   input  wire tdpt_pkg::tdpt_cmd_type   cmd,
   output tdpt_pkg::tdpt_status_type     status
);
   import tdpt_pkg::*;

   localparam int DW = (WIDTH + 1) / 2 + 1;
   localparam int CW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] num_ff, num_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [DW-1:0]    div_ff, div_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DW:0]      rem_shift;
   logic [DW:0]      rem_diff;
   logic             fits;

   assign rem_shift = {rem_ff, quo_ff[WIDTH-1]};
   assign rem_diff  = rem_shift - (DW+1)'(div_ff);
   assign fits      = rem_shift >= (DW+1)'(div_ff);

   always_comb begin
      num_in = num_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         num_in = number;
         div_in = DW'(FIRST_DIVISOR);
      end
      if (cmd.next_divisor) begin
         div_in = div_ff + DW'(DIVISOR_STEP);
      end
      if (cmd.div_init) begin
         quo_in = num_ff;
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[WIDTH-2:0], fits};
         rem_in = fits ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
         cnt_in = cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign status.below_two    = (num_ff[WIDTH-1:1] == '0);
   assign status.equals_two   = (num_ff == WIDTH'(LOWEST_PRIME));
   assign status.is_even      = !num_ff[0];
   assign status.step_last    = (cnt_ff == CW'(WIDTH - 1));
   assign status.rem_zero     = (rem_ff == '0);
   assign status.div_in_range = (WIDTH'(div_ff) <= quo_ff);
endmodule
`default_nettype wire

[sv/tdpt_ctrl.sv]
// Controller: sequences screening, one division per trial divisor, and the result.
// Depends on tdpt_pkg.
`default_nettype none
module tdpt_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire tdpt_pkg::tdpt_status_type status,
   output tdpt_pkg::tdpt_cmd_type         cmd,
   output logic                           busy,
   output logic                           rsp_strobe,
   output logic                           rsp_is_prime
);
   import tdpt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCREEN,
      ST_DIVIDE,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;
   logic      prime_ff, prime_in;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      prime_in  = prime_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCREEN;
            end
         end
         ST_SCREEN: begin
            priority if (status.below_two) begin
               strobe_in = 1'b1;
               prime_in  = 1'b0;
               state_in  = ST_IDLE;
            end else if (status.equals_two) begin
               strobe_in = 1'b1;
               prime_in  = 1'b1;
               state_in  = ST_IDLE;
            end else if (status.is_even) begin
               strobe_in = 1'b1;
               prime_in  = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (!status.div_in_range) begin
               strobe_in = 1'b1;
               prime_in  = 1'b1;
               state_in  = ST_IDLE;
            end else if (status.rem_zero) begin
               strobe_in = 1'b1;
               prime_in  = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               cmd.next_divisor = 1'b1;
               cmd.div_init     = 1'b1;
               state_in         = ST_DIVIDE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      prime_ff <= prime_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_is_prime = prime_ff;
endmodule
`default_nettype wire

[sv/trial_division_prime_test.sv]
// Top level of the trial division prime test: controller plus datapath.
// Depends on tdpt_pkg, tdpt_ctrl, tdpt_dp and trial_division_prime_test_assert.svh.
//
// A request is taken at a rising edge where start is high and busy is low; the
// number to test is sampled from req_number at that edge. Busy stays high
// while the request is worked on. The answer appears on rsp_is_prime, marked
// by rsp_strobe, high for exactly one cycle, in the same cycle that busy drops.
// The receiver cannot hold the result off, and a new request may be started
// in that same cycle.
// Numbers below two, two itself and even numbers are settled in the screening
// state. Odd numbers run one restoring division per odd trial divisor, each
// followed by a decision state, until the divisor exceeds the quotient or
// divides the number. One request is in flight at a time.
// Synchronous reset returns the controller to idle and drops the strobe.
`default_nettype none
`include "trial_division_prime_test_assert.svh"
module trial_division_prime_test #(
   parameter int WIDTH = tdpt_pkg::WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [WIDTH-1:0] req_number,
   output logic                  rsp_strobe,
   output logic                  rsp_is_prime
);
   import tdpt_pkg::*;

   tdpt_cmd_type    cmd;
   tdpt_status_type status;

   tdpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_is_prime (rsp_is_prime)
   );

   tdpt_dp #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock  (clock),
      .number (req_number),
      .cmd    (cmd),
      .status (status)
   );

   `TDPT_ASSERT_IMPLIES(a_strobe_when_idle, clock, reset, rsp_strobe, !busy)
   `TDPT_ASSERT_NEXT(a_start_sets_busy, clock, reset, start && !busy, busy)
   `TDPT_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)
endmodule
`default_nettype wire

[test/tb_trial_division_prime_test.sv]
// Testbench for trial_division_prime_test: directed and random numbers go in over the
// start/busy request port, and each strobed answer is checked against a trial-division predictor.
// Depends on tdpt_pkg and the trial_division_prime_test RTL.
`timescale 1ns / 1ps

module tb_trial_division_prime_test;
   import tdpt_pkg::*;

   localparam int NUM_WIDTH = WIDTH_DEFAULT;
   localparam int RANDOM_REQUESTS = 100;
   localparam int STALL_LIMIT = 100000;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_GAP = 16;

   localparam logic [NUM_WIDTH-1:0] DIRECTED_NUMBERS[22] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9, 32'd15,
      32'd25, 32'd49, 32'd121, 32'd63001, 32'd65537, 32'd1000003, 32'd1018081,
      32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h5555_5555, 32'h7FFF_FFFE
   };

   class prime_scoreboard;
      bit          expected_verdicts[$];
      int unsigned error_count;

      function bit trial_divide(logic [NUM_WIDTH-1:0] number);
         longint unsigned n;
         longint unsigned d;
         n = number;
         if (n < LOWEST_PRIME) return 1'b0;
         if (n == LOWEST_PRIME) return 1'b1;
         if (n % 2 == 0) return 1'b0;
         for (d = FIRST_DIVISOR; d <= n / d; d += DIVISOR_STEP) begin
            if (n % d == 0) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_request(logic [NUM_WIDTH-1:0] number);
         expected_verdicts.push_back(trial_divide(number));
      endfunction

      function void check_result(logic is_prime);
         bit verdict;
         if (expected_verdicts.size() == 0) begin
            $error("is_prime: expected no result, actual %0b", is_prime);
            error_count++;
            return;
         end
         verdict = expected_verdicts.pop_front();
         if (is_prime !== verdict) begin
            $error("is_prime: expected %0b, actual %0b", verdict, is_prime);
            error_count++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic [NUM_WIDTH-1:0] req_number = '0;
   logic                 busy;
   logic                 rsp_strobe;
   logic                 rsp_is_prime;

   prime_scoreboard verdicts;
   int unsigned     stall_cycles = 0;

   trial_division_prime_test #(
      .WIDTH(NUM_WIDTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_number(req_number),
      .rsp_strobe(rsp_strobe),
      .rsp_is_prime(rsp_is_prime)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) verdicts.check_result(rsp_is_prime);
         if (rsp_strobe === 1'b1 || (start && busy === 1'b0)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   task automatic send_number(input logic [NUM_WIDTH-1:0] number, input int unsigned gap);
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
         req_number = $urandom;
      end
      @(negedge clock);
      start = 1'b1;
      req_number = number;
      do @(posedge clock); while (busy !== 1'b0);
      verdicts.note_request(number);
   endtask

   initial begin
      int unsigned          k;
      int unsigned          gap;
      bit                   no_gaps;
      logic [NUM_WIDTH-1:0] number;
      longint unsigned      p;
      longint unsigned      q;
      verdicts = new();
      no_gaps = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_NUMBERS[i]) send_number(DIRECTED_NUMBERS[i], $urandom_range(0, MAX_GAP));

      for (k = 0; k < RANDOM_REQUESTS; k++) begin
         if (k % 10 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: number = $urandom_range(0, 4095);
            5: number = $urandom_range(0, 1 << 20) | 1;
            6: number = $urandom & ~32'd1;
            7: begin
               p = $urandom_range(0, 715827882);
               number = NUM_WIDTH'(3 * (2 * p + 1));
            end
            8: begin
               do p = 2 * $urandom_range(1, 125) + 1;
               while (!verdicts.trial_divide(NUM_WIDTH'(p)));
               do q = 2 * $urandom_range(1, 125) + 1;
               while (!verdicts.trial_divide(NUM_WIDTH'(q)));
               number = NUM_WIDTH'(p * q);
            end
            default: number = $urandom_range(0, 65535);
         endcase
         gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         send_number(number, gap);
      end

      @(negedge clock);
      start = 1'b0;
      while (verdicts.expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdicts.error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+sv
sv/tdpt_pkg.sv
sv/tdpt_dp.sv
sv/tdpt_ctrl.sv
sv/trial_division_prime_test.sv
test/tb_trial_division_prime_test.sv
